// File: design/restriction_site_screen_macros.svh
// ---------------------------------------------------------------------------
// Restriction site screen assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef RESTRICTION_SITE_SCREEN_MACROS_SVH
`define RESTRICTION_SITE_SCREEN_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("restriction_site_screen: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("restriction_site_screen: next-cycle check failed");

`endif

// File: design/rss_pkg.sv
// ---------------------------------------------------------------------------
// Restriction site screen package
// Motif table, assembly standard masks and shared widths.
// ---------------------------------------------------------------------------
package rss_pkg;

  localparam int unsigned BASE_W      = 8;
  localparam int unsigned HIST_DEPTH  = 7;
  localparam int unsigned WIN_BYTES   = HIST_DEPTH + 1;
  localparam int unsigned WIN_W       = WIN_BYTES * BASE_W;
  localparam int unsigned MOTIF_COUNT = 15;
  localparam int unsigned STD_COUNT   = 6;

  typedef logic [BASE_W-1:0]      base_t;
  typedef logic [HIST_DEPTH-1:0][BASE_W-1:0] hist_t;
  typedef logic [WIN_W-1:0]       window_t;
  typedef logic [MOTIF_COUNT-1:0] motif_mask_t;
  typedef logic [STD_COUNT-1:0]   std_mask_t;
  typedef logic [3:0]             motif_len_t;

  // The last character of each motif sits in the low byte.
  localparam window_t MOTIF_SEQ [MOTIF_COUNT] = '{
    window_t'("GAATTC"),   window_t'("TCTAGA"),  window_t'("ACTAGT"),
    window_t'("CTGCAG"),   window_t'("GCGGCCGC"), window_t'("GCTAGC"),
    window_t'("CAGCTG"),   window_t'("CTCGAG"),  window_t'("CCTAGG"),
    window_t'("GCTCTTC"),  window_t'("GAAGAGC"), window_t'("GGATCC"),
    window_t'("AGATCT"),   window_t'("GCCGGC"),  window_t'("ACCGGT")
  };

  localparam motif_len_t MOTIF_LEN [MOTIF_COUNT] = '{
    4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd7, 4'd7, 4'd6, 4'd6, 4'd6, 4'd6
  };

  localparam motif_mask_t STD_MASK [STD_COUNT] = '{
    15'h001F, 15'h003D, 15'h07C2, 15'h1881, 15'h001F, 15'h601F
  };

  function automatic window_t motif_byte_mask(motif_len_t len);
    window_t mask;
    mask = '0;
    for (int k = 0; k < WIN_BYTES; k++) begin
      if (k < int'(len)) begin
        mask[k*BASE_W +: BASE_W] = '1;
      end
    end
    return mask;
  endfunction

endpackage

// File: design/rss_stream_if.sv
// ---------------------------------------------------------------------------
// Restriction site screen stream interfaces
// Valid/ready channels for sequence bytes in and screen results out.
// ---------------------------------------------------------------------------
interface rss_in_if
  import rss_pkg::*;
;
  logic  valid;
  logic  ready;
  base_t base;
  logic  last;

  modport source (output valid, output base, output last, input ready);
  modport sink   (input valid, input base, input last, output ready);
endinterface

interface rss_out_if
  import rss_pkg::*;
;
  logic        valid;
  logic        ready;
  logic        accepted;
  std_mask_t   violated_standards;
  motif_mask_t found_motifs;

  modport source (output valid, output accepted, output violated_standards,
                  output found_motifs, input ready);
  modport sink   (input valid, input accepted, input violated_standards,
                  input found_motifs, output ready);
endinterface

// File: design/rss_matcher.sv
// ---------------------------------------------------------------------------
// Restriction site screen motif matcher
// Compares the eight-byte window against every motif in parallel.
// ---------------------------------------------------------------------------
module rss_matcher
  import rss_pkg::*;
(
  input  window_t     window,
  output motif_mask_t hits
);

  always_comb begin
    for (int m = 0; m < MOTIF_COUNT; m++) begin
      hits[m] = (window & motif_byte_mask(MOTIF_LEN[m])) == MOTIF_SEQ[m];
    end
  end

endmodule

// File: design/restriction_site_screen.sv
// ---------------------------------------------------------------------------
// Restriction site screen
// Screens a streamed sequence for fixed restriction motifs per standard.
// ---------------------------------------------------------------------------
// The block takes one sequence byte per cycle and matches the byte with the
// seven bytes before it against all fifteen motifs in the same cycle. The
// result word for a sequence appears in the output register in the cycle
// after its last byte is accepted. in_ch.ready is low only while a result
// word is held and out_ch.ready is low. The history and motif mask clear as
// the last byte is taken, so the next sequence may follow in the next cycle.
module restriction_site_screen
  import rss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rss_in_if.sink      in_ch,
  rss_out_if.source   out_ch,
  input  logic        cfg_we,
  input  std_mask_t   cfg_wdata
);

  std_mask_t   enable_r;
  hist_t       hist_r, hist_nxt;
  motif_mask_t seen_r, seen_nxt;
  motif_mask_t hits, seen_all;
  std_mask_t   violated;
  logic        out_valid_r, out_valid_nxt;
  logic        accepted_r;
  std_mask_t   violated_r;
  motif_mask_t found_r;
  logic        in_fire;

  rss_matcher u_matcher (
    .window ({hist_r, in_ch.base}),
    .hits   (hits)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign seen_all    = seen_r | hits;

  always_comb begin
    for (int s = 0; s < STD_COUNT; s++) begin
      violated[s] = enable_r[s] && ((seen_all & STD_MASK[s]) != '0);
    end
  end

  always_comb begin
    hist_nxt      = hist_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (in_fire) begin
      if (in_ch.last) begin
        hist_nxt      = '0;
        seen_nxt      = '0;
        out_valid_nxt = 1'b1;
      end else begin
        hist_nxt = {hist_r[HIST_DEPTH-2:0], in_ch.base};
        seen_nxt = seen_all;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= '0;
      hist_r      <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
      hist_r      <= hist_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.last) begin
      accepted_r <= (violated == '0);
      violated_r <= violated;
      found_r    <= seen_all;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.accepted           = accepted_r;
  assign out_ch.violated_standards = violated_r;
  assign out_ch.found_motifs       = found_r;

endmodule

// File: design/rss_checker.sv
// ---------------------------------------------------------------------------
// Restriction site screen checker
// Port-level assertions on the screen's channels, bound to the top level.
// ---------------------------------------------------------------------------
`include "restriction_site_screen_macros.svh"

module rss_checker
  import rss_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input std_mask_t   out_violated
);

  `RSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `RSS_ASSERT_SAME(a_accept_code, out_valid, out_accepted == (out_violated == '0))
  `RSS_ASSERT_NEXT(a_last_gives_word, in_valid && in_ready && in_last, out_valid)
  `RSS_ASSERT_NEXT(a_no_word_mid_seq,
                   in_valid && in_ready && !in_last && !out_valid, !out_valid)
  `RSS_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

endmodule

bind restriction_site_screen rss_checker u_rss_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_last      (in_ch.last),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_accepted (out_ch.accepted),
  .out_violated (out_ch.violated_standards)
);
